### hdl/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg: shared types and constants of the infix-to-postfix converter
// Holds the stack geometry, the character type, the stack operation codes
// and the character codes that the control logic recognizes.
// ----------------------------------------------------------------------------
package itp_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    typedef logic [7:0] t_char;

    typedef enum logic [1:0] {
        ST_HOLD,
        ST_PUSH,
        ST_POP
    } t_stack_op;

    localparam t_char CH_LPAREN = 8'h28;  // '('
    localparam t_char CH_RPAREN = 8'h29;  // ')'
    localparam t_char CH_PLUS   = 8'h2B;  // '+'
    localparam t_char CH_MINUS  = 8'h2D;  // '-'
    localparam t_char CH_STAR   = 8'h2A;  // '*'
    localparam t_char CH_SLASH  = 8'h2F;  // '/'
    localparam t_char CH_CARET  = 8'h5E;  // '^'
    localparam t_char CH_NUL    = 8'h00;  // terminator

endpackage

### hdl/itp_in_if.sv
// ----------------------------------------------------------------------------
// itp_in_if: input request channel
// Carries one infix character and the end-of-expression mark.
// ----------------------------------------------------------------------------
interface itp_in_if;
    import itp_pkg::*;

    logic  valid;
    logic  ready;
    t_char in_char;
    logic  expr_last;

    modport source (output valid, output in_char, output expr_last, input ready);
    modport sink   (input valid, input in_char, input expr_last, output ready);
endinterface

### hdl/itp_out_if.sv
// ----------------------------------------------------------------------------
// itp_out_if: output request channel
// Carries one postfix character with its framing and status flags.
// ----------------------------------------------------------------------------
interface itp_out_if;
    import itp_pkg::*;

    logic  valid;
    logic  ready;
    t_char out_char;
    logic  run_last;
    logic  expr_end;
    logic  overflow;

    modport source (output valid, output out_char, output run_last,
                    output expr_end, output overflow, input ready);
    modport sink   (input valid, input out_char, input run_last,
                    input expr_end, input overflow, output ready);
endinterface

### hdl/itp_cell.sv
// ----------------------------------------------------------------------------
// itp_cell: one entry of the shifting operator stack
// Take the upper neighbor's entry on push, the lower neighbor's on pop.
// ----------------------------------------------------------------------------
module itp_cell (
    input  logic              i_clk,
    input  itp_pkg::t_stack_op i_op,
    input  itp_pkg::t_char    i_from_up,
    input  itp_pkg::t_char    i_from_down,
    output itp_pkg::t_char    o_data
);
    import itp_pkg::*;

    t_char r_data;

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            ST_PUSH: r_data <= i_from_up;
            ST_POP:  r_data <= i_from_down;
            default: r_data <= r_data;
        endcase
    end

    assign o_data = r_data;

endmodule

### hdl/itp_stack.sv
// ----------------------------------------------------------------------------
// itp_stack: operator stack built as a chain of cells
// Cell zero is the top; push shifts down the chain, pop shifts up.
// ----------------------------------------------------------------------------
module itp_stack (
    input  logic               i_clk,
    input  itp_pkg::t_stack_op i_op,
    input  itp_pkg::t_char     i_push_data,
    output itp_pkg::t_char     o_top,
    output itp_pkg::t_char     o_second
);
    import itp_pkg::*;

    t_char w_data [STACK_DEPTH];

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        t_char w_up;
        t_char w_down;

        if (g == 0) begin : g_top
            assign w_up = i_push_data;
        end else begin : g_mid
            assign w_up = w_data[g-1];
        end

        if (g == STACK_DEPTH - 1) begin : g_bottom
            assign w_down = CH_NUL;
        end else begin : g_inner
            assign w_down = w_data[g+1];
        end

        itp_cell u_cell (
            .i_clk       (i_clk),
            .i_op        (i_op),
            .i_from_up   (w_up),
            .i_from_down (w_down),
            .o_data      (w_data[g])
        );
    end

    assign o_top    = w_data[0];
    assign o_second = w_data[1];

endmodule

### hdl/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter: shunting-yard conversion, one character a request
// A request is taken only in the idle state; the held character is then worked off
//   (operators popped to the output, then a push or a pass) before the next is
//   taken, and a final character also drains the stack and sends the terminator.
// The cell chain makes one stack shift per cycle, none while a pop waits on output.
// Reset (synchronous, active low) empties the stack and clears overflow.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    itp_in_if.sink      i_in,
    itp_out_if.source   o_out
);
    import itp_pkg::*;

    // Precedence: + - are 1, * / are 2, ^ is 3, everything else -1.
    function automatic logic signed [2:0] prec_of(input t_char c);
        logic signed [2:0] p;
        begin
            unique case (c)
                CH_PLUS, CH_MINUS: p = 3'sd1;
                CH_STAR, CH_SLASH: p = 3'sd2;
                CH_CARET:          p = 3'sd3;
                default:           p = -3'sd1;
            endcase
            return p;
        end
    endfunction

    function automatic logic is_letter(input t_char c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    typedef enum logic [1:0] {
        S_IDLE,   // wait for a character
        S_WORK,   // pop, push or pass the held character
        S_FLUSH   // drain the stack, then send the terminator
    } t_state;

    t_state              r_state, n_state;
    t_char               r_char;
    logic                r_last;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_ovf, n_ovf;

    // Output register
    logic                r_out_valid;
    t_char               r_out_char;
    logic                r_out_run_last;
    logic                r_out_expr_end;
    logic                r_out_ovf;

    // Stack chain
    t_stack_op           w_op;
    t_char               w_top;
    t_char               w_second;

    // Result produced this cycle
    logic                w_emit;
    t_char               w_emit_char;
    logic                w_emit_run_last;
    logic                w_emit_end;

    logic                w_accept;
    logic                w_out_free;
    logic                w_empty;
    logic                w_full;
    logic                w_top_wins;
    logic                w_second_wins;
    logic                w_more;

    itp_stack u_stack (
        .i_clk       (i_clk),
        .i_op        (w_op),
        .i_push_data (r_char),
        .o_top       (w_top),
        .o_second    (w_second)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_empty     = (r_cnt == '0);
    assign w_full      = (r_cnt == CNT_W'(STACK_DEPTH));
    // Held character yields to the top (and to the entry beneath it)
    assign w_top_wins    = (prec_of(r_char) <= prec_of(w_top));
    assign w_second_wins = (prec_of(r_char) <= prec_of(w_second));
    assign w_more        = (r_cnt > CNT_W'(1));

    always_comb begin
        n_state         = r_state;
        n_cnt           = r_cnt;
        n_ovf           = r_ovf;
        w_op            = ST_HOLD;
        w_emit          = 1'b0;
        w_emit_char     = w_top;
        w_emit_run_last = 1'b0;
        w_emit_end      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_WORK;
                end
            end

            S_WORK: begin
                priority if (is_letter(r_char)) begin
                    // pass letters straight through
                    if (w_out_free) begin
                        w_emit          = 1'b1;
                        w_emit_char     = r_char;
                        w_emit_run_last = !r_last;
                        n_state         = r_last ? S_FLUSH : S_IDLE;
                    end
                end else if (r_char == CH_LPAREN) begin
                    if (w_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        w_op  = ST_PUSH;
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                    n_state = r_last ? S_FLUSH : S_IDLE;
                end else if (r_char == CH_RPAREN) begin
                    if (!w_empty && (w_top != CH_LPAREN)) begin
                        // pop until the matching '('
                        if (w_out_free) begin
                            w_emit          = 1'b1;
                            w_emit_run_last = !r_last &&
                                              (!w_more || (w_second == CH_LPAREN));
                            w_op            = ST_POP;
                            n_cnt           = r_cnt - CNT_W'(1);
                        end
                    end else begin
                        // drop the '(' if there is one
                        if (!w_empty) begin
                            w_op  = ST_POP;
                            n_cnt = r_cnt - CNT_W'(1);
                        end
                        n_state = r_last ? S_FLUSH : S_IDLE;
                    end
                end else begin
                    if (!w_empty && w_top_wins) begin
                        if (w_out_free) begin
                            w_emit          = 1'b1;
                            w_emit_run_last = !r_last && !(w_more && w_second_wins);
                            w_op            = ST_POP;
                            n_cnt           = r_cnt - CNT_W'(1);
                        end
                    end else begin
                        if (w_full) begin
                            n_ovf = 1'b1;
                        end else begin
                            w_op  = ST_PUSH;
                            n_cnt = r_cnt + CNT_W'(1);
                        end
                        n_state = r_last ? S_FLUSH : S_IDLE;
                    end
                end
            end

            S_FLUSH: begin
                if (w_out_free) begin
                    w_emit = 1'b1;
                    if (!w_empty) begin
                        w_op  = ST_POP;
                        n_cnt = r_cnt - CNT_W'(1);
                    end else begin
                        // terminator shows the flag, then clear it
                        w_emit_char     = CH_NUL;
                        w_emit_end      = 1'b1;
                        w_emit_run_last = 1'b1;
                        n_ovf           = 1'b0;
                        n_state         = S_IDLE;
                    end
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            if (w_accept) begin
                r_char <= i_in.in_char;
                r_last <= i_in.expr_last;
            end
            if (w_emit) begin
                r_out_valid    <= 1'b1;
                r_out_char     <= w_emit_char;
                r_out_run_last <= w_emit_run_last;
                r_out_expr_end <= w_emit_end;
                r_out_ovf      <= r_ovf;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_char = r_out_char;
    assign o_out.run_last = r_out_run_last;
    assign o_out.expr_end = r_out_expr_end;
    assign o_out.overflow = r_out_ovf;

endmodule

### hdl/itp_checker.sv
// ----------------------------------------------------------------------------
// itp_checker: port-level checks of the infix-to-postfix converter
// Watches both request channels and flags framing, hold, pacing and reset violations.
// ----------------------------------------------------------------------------
module itp_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           i_in_ready,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input itp_pkg::t_char i_out_char,
    input logic           i_out_run_last,
    input logic           i_out_expr_end
);
    import itp_pkg::*;

    // Terminator is a zero character that closes the item's run
    a_term_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_expr_end) |-> (i_out_run_last && (i_out_char == CH_NUL)))
        else $error("terminator not framed as last zero result");

    // One character at a time: no back-to-back accepted inputs
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input accepted while previous character in work");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_char) && $stable(i_out_expr_end)))
        else $error("stalled result changed");

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_char     (o_out.out_char),
    .i_out_run_last (o_out.run_last),
    .i_out_expr_end (o_out.expr_end)
);
